/* hw/rtl/rsm_pkg.sv */
package rsm_pkg;

  localparam int ROW_MAX   = 64;
  localparam int DEPTH     = 64;
  localparam int ADDR_W    = 6;
  localparam int CNT_W     = 7;
  localparam int SUM_W     = 22;
  localparam int EXP_STEPS = 12;
  localparam int DIV_STEPS = 34;

  typedef enum logic [2:0] {
    S_LOAD,
    S_EXP_RD,
    S_EXP_GO,
    S_EXP_WAIT,
    S_DIV_RD,
    S_DIV_GO,
    S_DIV_WAIT
  } state_t;

  // exp(-2^k/256) in Q0.32
  function automatic logic [31:0] exp_coef(input logic [3:0] k);
    logic [31:0] c;
    case (k)
      4'd0:    c = 32'd4278222805;
      4'd1:    c = 32'd4261543595;
      4'd2:    c = 32'd4228380000;
      4'd3:    c = 32'd4162825044;
      4'd4:    c = 32'd4034748382;
      4'd5:    c = 32'd3790295335;
      4'd6:    c = 32'd3344923893;
      4'd7:    c = 32'd2605029347;
      4'd8:    c = 32'd1580030169;
      4'd9:    c = 32'd581260616;
      4'd10:   c = 32'd78665070;
      4'd11:   c = 32'd1440801;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/rsm_ram.sv */
module rsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/rsm_exp.sv */
module rsm_exp (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] delta,
  output logic        busy,
  output logic [15:0] e
);
  import rsm_pkg::*;

  logic [3:0]  k;
  logic [11:0] bits;
  logic [31:0] acc;
  logic        acc_one;
  logic        big;
  logic [63:0] prod;
  logic [16:0] rounded;

  assign prod    = 64'(acc) * 64'(exp_coef(k)) + 64'h8000_0000;
  assign rounded = 17'((33'(acc) + 33'h8000) >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && k == 4'(EXP_STEPS - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k       <= 4'd0;
      bits    <= delta[11:0];
      big     <= |delta[15:12];
      acc_one <= 1'b1;
    end else if (busy) begin
      k <= k + 4'd1;
      if (bits[k]) begin
        // skip the first multiply: 1.0 times a coefficient is the coefficient
        acc     <= acc_one ? exp_coef(k) : prod[63:32];
        acc_one <= 1'b0;
      end
    end
  end

  always_comb begin
    if (big) begin
      e = 16'd0;
    end else if (acc_one || rounded[16]) begin
      e = 16'hFFFF;
    end else begin
      e = rounded[15:0];
    end
  end

endmodule

/* hw/rtl/rsm_div.sv */
module rsm_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [15:0]              e,
  input  logic [rsm_pkg::SUM_W-1:0] sum,
  output logic                     busy,
  output logic [15:0]              prob
);
  import rsm_pkg::*;

  logic [DIV_STEPS-1:0] num;
  logic [SUM_W:0]       dvs;
  logic [SUM_W+1:0]     rem;
  logic [SUM_W+1:0]     trial;
  logic [5:0]           cnt;
  logic                 fits;

  assign trial = {rem[SUM_W:0], num[DIV_STEPS-1]};
  assign fits  = trial >= (SUM_W+2)'(dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 6'(DIV_STEPS - 1)) begin
      busy <= 1'b0;
    end
  end

  // restoring division; num shifts out numerator bits and takes in quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      num <= (DIV_STEPS'(e) << 17) - (DIV_STEPS'(e) << 1) + DIV_STEPS'(sum);
      dvs <= {sum, 1'b0};
      rem <= '0;
      cnt <= 6'd0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      num <= {num[DIV_STEPS-2:0], fits};
      rem <= fits ? trial - (SUM_W+2)'(dvs) : trial;
    end
  end

  always_comb begin
    if (dvs == '0) begin
      prob = 16'd0;
    end else if (|num[DIV_STEPS-1:16]) begin
      prob = 16'hFFFF;
    end else begin
      prob = num[15:0];
    end
  end

endmodule

/* hw/rtl/row_softmax.sv */
// Channel  Direction  Handshake            Word
// input    in         in_valid / in_stall   logit, row_end
// output   out        out_valid / out_stall prob, position, final_item, truncated
//
// Loading accepts one element per cycle; in_stall stays low until the word with row_end.
// Then each stored element goes through the exponential pass (one
// Q0.32 multiply a cycle over 12 steps) and then the normalization pass
// (a bit-serial divider, one quotient bit a cycle over 34 bits).
// rst clears the controller; both stores are valid only for the current row.
// A held output word holds the normalization pass until out_stall drops.
module row_softmax (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] logit,
  input  logic        row_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] prob,
  output logic [5:0]  position,
  output logic        final_item,
  output logic        truncated
);
  import rsm_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]  fill_count;
  logic signed [15:0] row_max;
  logic [SUM_W-1:0]  exp_sum;
  logic              overflow_seen;
  logic [ADDR_W-1:0] idx;

  logic              in_take;
  logic              has_room;
  logic              last_idx;
  logic              out_free;

  logic              row_we;
  logic [ADDR_W-1:0] row_raddr;
  logic [15:0]       row_rdata;
  logic              exp_we;
  logic [15:0]       exp_rdata;

  logic              exp_start, exp_busy;
  logic [15:0]       exp_val;
  logic [16:0]       delta;
  logic              div_start, div_busy;
  logic [15:0]       div_prob;
  logic              emit;

  assign in_take  = in_valid && !in_stall;
  assign has_room = fill_count < CNT_W'(ROW_MAX);
  assign last_idx = idx == ADDR_W'(fill_count - CNT_W'(1));
  assign out_free = !out_valid || !out_stall;
  assign delta    = {row_max[15], row_max} - {row_rdata[15], row_rdata};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:     if (in_take && row_end) state_next = S_EXP_RD;
      S_EXP_RD:   state_next = S_EXP_GO;
      S_EXP_GO:   state_next = S_EXP_WAIT;
      S_EXP_WAIT: if (!exp_busy) state_next = last_idx ? S_DIV_RD : S_EXP_RD;
      S_DIV_RD:   state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (!div_busy && out_free) state_next = last_idx ? S_LOAD : S_DIV_RD;
      default:    state_next = S_LOAD;
    endcase
  end

  // controls
  always_comb begin
    in_stall  = 1'b1;
    row_we    = 1'b0;
    exp_start = 1'b0;
    exp_we    = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    case (state)
      S_LOAD: begin
        in_stall = 1'b0;
        row_we   = in_take && has_room;
      end
      S_EXP_GO:   exp_start = 1'b1;
      S_EXP_WAIT: exp_we = !exp_busy;
      S_DIV_GO:   div_start = 1'b1;
      S_DIV_WAIT: emit = !div_busy && out_free;
      default: begin
      end
    endcase
  end

  assign row_raddr = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      fill_count    <= '0;
      row_max       <= '0;
      exp_sum       <= '0;
      overflow_seen <= 1'b0;
      idx           <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_take) begin
            if (has_room) begin
              if (fill_count == '0 || $signed(logit) > row_max) begin
                row_max <= $signed(logit);
              end
              fill_count <= fill_count + CNT_W'(1);
            end else begin
              // drop the word; a dropped row_end still closes the row
              overflow_seen <= 1'b1;
            end
            if (row_end) begin
              idx     <= '0;
              exp_sum <= '0;
            end
          end
        end
        S_EXP_WAIT: begin
          if (!exp_busy) begin
            exp_sum <= exp_sum + SUM_W'(exp_val);
            idx     <= last_idx ? '0 : idx + ADDR_W'(1);
          end
        end
        S_DIV_WAIT: begin
          if (emit) begin
            idx <= last_idx ? '0 : idx + ADDR_W'(1);
            if (last_idx) begin
              fill_count    <= '0;
              row_max       <= '0;
              overflow_seen <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output word; payload needs no reset
  always_ff @(posedge clk) begin
    if (emit) begin
      prob       <= div_prob;
      position   <= idx;
      final_item <= last_idx;
      truncated  <= overflow_seen;
    end
  end

  rsm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (fill_count[ADDR_W-1:0]),
    .wdata (logit),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  rsm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (idx),
    .wdata (exp_val),
    .raddr (idx),
    .rdata (exp_rdata)
  );

  rsm_exp u_exp (
    .clk   (clk),
    .rst   (rst),
    .start (exp_start),
    .delta (delta[15:0]),
    .busy  (exp_busy),
    .e     (exp_val)
  );

  rsm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .e     (exp_rdata),
    .sum   (exp_sum),
    .busy  (div_busy),
    .prob  (div_prob)
  );

endmodule
